// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
// The asserting scope must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic concurrent assertion, disabled while reset is asserted.
`define GQG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define GQG_ASSERT_IMP(lbl, ante, cons, msg) `GQG_ASSERT(lbl, ante |-> cons, msg)

// Next-cycle implication.
`define GQG_ASSERT_NXT(lbl, ante, cons, msg) `GQG_ASSERT(lbl, ante |=> cons, msg)

`endif

// File: rtl/core/gqg_pkg.sv
`default_nettype none

package gqg_pkg;

  // Atlas cell geometry
  localparam int CELL_W = 8;
  localparam int CELL_H = 16;

  localparam int CODE_W     = 8;
  localparam int COORD_W    = 16;
  localparam int GLYPH_W    = 8;
  localparam int COLOR_W    = 32;
  localparam int ALPHA_W    = 8;
  localparam int TEX_U_W    = 12;
  localparam int TEX_V_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CUR_W      = 16;
  localparam int PROD_W     = CUR_W + GLYPH_W;
  localparam int POS_W      = PROD_W + 3;
  localparam int FACTOR_W   = 9;
  localparam int VTX_CNT_W  = 3;
  localparam int U_FULL_W   = 16;

  localparam logic [CODE_W-1:0]   CHAR_NEWLINE = 8'd10;
  localparam logic [FACTOR_W-1:0] ALPHA_ONE    = 9'd256;
  localparam int                  SHADOW_EN_BIT = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X       = 3'd0,
    CFG_ORIGIN_Y       = 3'd1,
    CFG_GLYPH_WIDTH    = 3'd2,
    CFG_GLYPH_HEIGHT   = 3'd3,
    CFG_MAX_COLUMNS    = 3'd4,
    CFG_TEXT_COLOR     = 3'd5,
    CFG_SHADOW_OFFSET  = 3'd6,
    CFG_SHADOW_SETTING = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [GLYPH_W-1:0]        glyph_width;
    logic [GLYPH_W-1:0]        glyph_height;
    logic [GLYPH_W-1:0]        max_columns;
    logic [COLOR_W-1:0]        text_color;
    logic signed [COORD_W-1:0] shadow_dx;
    logic signed [COORD_W-1:0] shadow_dy;
    logic                      shadow_en;
    logic [FACTOR_W-1:0]       shadow_factor;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic mul;
    logic base;
    logic offs;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_newline;
    logic last_vtx;
    logic out_free;
  } status_t;

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [POS_W-1:0] v);
    logic in_range;
    in_range = (&v[POS_W-1:COORD_W-1]) || !(|v[POS_W-1:COORD_W-1]);
    if (in_range) begin
      return v[COORD_W-1:0];
    end else if (v[POS_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  function automatic logic [CUR_W-1:0] inc_sat(input logic [CUR_W-1:0] v);
    if (&v) begin
      return v;
    end else begin
      return v + CUR_W'(1);
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gqg_char_if.sv
`default_nettype none

interface gqg_char_if import gqg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] char_code;
  logic              start_of_text;

  modport source (output valid, output char_code, output start_of_text, input ready);
  modport sink   (input valid, input char_code, input start_of_text, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gqg_vertex_if.sv
`default_nettype none

interface gqg_vertex_if import gqg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic [TEX_U_W-1:0]        tex_u;
  logic [TEX_V_W-1:0]        tex_v;
  logic [COLOR_W-1:0]        vertex_color;
  logic                      last_of_run;

  modport source (output valid, output vertex_x, output vertex_y, output tex_u,
                  output tex_v, output vertex_color, output last_of_run, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input tex_u,
                  input tex_v, input vertex_color, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/core/glyph_quad_generator_unit.sv
// A character is accepted in IDLE; MUL, BASE and OFFS follow, then EMIT loads its 4 vertices
//   (8 with shadow) into the output register, one per cycle while the output is not stalled.
//   A newline only moves the cursor; a new character waits until the last vertex is emitted.
// Reset (rst_ni, async, active low): cursor at row 0 column 0, registers at defaults,
//   no vertex pending.
`default_nettype none

module glyph_quad_generator_unit import gqg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  gqg_char_if.sink                   chr_in,
  gqg_vertex_if.source               vtx_out,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Structure:
  //   gqg_cfg_regs  - register file written through the plain write port
  //   gqg_ctrl      - one-hot sequencer: IDLE -> MUL -> BASE -> OFFS -> EMIT
  //   gqg_datapath  - cursor, position multiply/add chain, vertex emitter
  //                   and the output register that holds a beat until taken
  //
  // Datapath steps per glyph:
  //   MUL : column * glyph_width, row * glyph_height
  //   BASE: add the origin, then advance the cursor (wrap when configured)
  //   OFFS: shadow quad corner and shadow alpha
  //   EMIT: one vertex per cycle into the output register; the output
  //         register reloads in the same cycle its beat is taken, so
  //         vertices stream at full rate while the sink keeps ready high.

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  gqg_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  gqg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (chr_in.valid),
    .in_ready_o (chr_in.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gqg_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .char_code_i     (chr_in.char_code),
    .start_of_text_i (chr_in.start_of_text),
    .out_ready_i     (vtx_out.ready),
    .out_valid_o     (vtx_out.valid),
    .vertex_x_o      (vtx_out.vertex_x),
    .vertex_y_o      (vtx_out.vertex_y),
    .tex_u_o         (vtx_out.tex_u),
    .tex_v_o         (vtx_out.tex_v),
    .vertex_color_o  (vtx_out.vertex_color),
    .last_of_run_o   (vtx_out.last_of_run)
  );

endmodule

`default_nettype wire

// File: rtl/core/gqg_cfg_regs.sv
`default_nettype none

module gqg_cfg_regs import gqg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.glyph_width   <= GLYPH_W'(8);
      cfg_q.glyph_height  <= GLYPH_W'(16);
      cfg_q.max_columns   <= '0;
      cfg_q.text_color    <= '1;
      cfg_q.shadow_dx     <= '0;
      cfg_q.shadow_dy     <= '0;
      cfg_q.shadow_en     <= 1'b0;
      cfg_q.shadow_factor <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:       cfg_q.origin_x     <= cfg_data_i[COORD_W-1:0];
        CFG_ORIGIN_Y:       cfg_q.origin_y     <= cfg_data_i[COORD_W-1:0];
        CFG_GLYPH_WIDTH:    cfg_q.glyph_width  <= cfg_data_i[GLYPH_W-1:0];
        CFG_GLYPH_HEIGHT:   cfg_q.glyph_height <= cfg_data_i[GLYPH_W-1:0];
        CFG_MAX_COLUMNS:    cfg_q.max_columns  <= cfg_data_i[GLYPH_W-1:0];
        CFG_TEXT_COLOR:     cfg_q.text_color   <= cfg_data_i[COLOR_W-1:0];
        CFG_SHADOW_OFFSET: begin
          cfg_q.shadow_dx <= cfg_data_i[2*COORD_W-1:COORD_W];
          cfg_q.shadow_dy <= cfg_data_i[COORD_W-1:0];
        end
        CFG_SHADOW_SETTING: begin
          cfg_q.shadow_en     <= cfg_data_i[SHADOW_EN_BIT];
          cfg_q.shadow_factor <= cfg_data_i[FACTOR_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/gqg_ctrl.sv
`default_nettype none

module gqg_ctrl import gqg_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  status_t   status_i,
  output cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_BASE = 5'b00100,
    ST_OFFS = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          // newline only moves the cursor
          if (!status_i.is_newline) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = ST_OFFS;
      end
      ST_OFFS: begin
        cmd_o.offs = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_vtx) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gqg_datapath.sv
`default_nettype none

module gqg_datapath import gqg_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  cfg_t                      cfg_i,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  input  wire logic [CODE_W-1:0]    char_code_i,
  input  wire logic                 start_of_text_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic signed [COORD_W-1:0] vertex_x_o,
  output logic signed [COORD_W-1:0] vertex_y_o,
  output logic [TEX_U_W-1:0]        tex_u_o,
  output logic [TEX_V_W-1:0]        tex_v_o,
  output logic [COLOR_W-1:0]        vertex_color_o,
  output logic                      last_of_run_o
);

  logic [CODE_W-1:0]       code_q;
  logic [CUR_W-1:0]        col_q, row_q;
  logic [PROD_W-1:0]       prod_x_q, prod_y_q;
  logic signed [POS_W-1:0] x0_q, y0_q, xs_q, ys_q;
  logic [ALPHA_W-1:0]      alpha_q;
  logic [VTX_CNT_W-1:0]    vtx_q;
  logic                    out_valid_q;

  logic [CUR_W-1:0]        col_sot, row_sot;
  logic                    wrap;
  logic [FACTOR_W-1:0]     factor;
  logic [2*ALPHA_W-1:0]    alpha_prod;
  logic                    right, bottom, text_phase;
  logic signed [POS_W-1:0] bx, by, vx, vy;
  logic [U_FULL_W-1:0]     u_full;

  assign status_o.is_newline = (char_code_i == CHAR_NEWLINE);
  assign status_o.last_vtx   = &vtx_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign col_sot = start_of_text_i ? '0 : col_q;
  assign row_sot = start_of_text_i ? '0 : row_q;
  assign wrap    = (cfg_i.max_columns != '0) &&
                   (col_q >= CUR_W'(cfg_i.max_columns - GLYPH_W'(1)));

  assign factor     = (cfg_i.shadow_factor > ALPHA_ONE) ? ALPHA_ONE : cfg_i.shadow_factor;
  assign alpha_prod = (2*ALPHA_W)'(cfg_i.text_color[ALPHA_W-1:0] * factor);

  // vertex order: top-left, top-right, bottom-right, bottom-left
  assign right      = vtx_q[0] ^ vtx_q[1];
  assign bottom     = vtx_q[1];
  assign text_phase = vtx_q[2];
  assign bx = text_phase ? x0_q : xs_q;
  assign by = text_phase ? y0_q : ys_q;
  assign vx = bx + (right  ? POS_W'(cfg_i.glyph_width)  : POS_W'(0));
  assign vy = by + (bottom ? POS_W'(cfg_i.glyph_height) : POS_W'(0));
  assign u_full = U_FULL_W'(code_q) * U_FULL_W'(CELL_W) +
                  (right ? U_FULL_W'(CELL_W) : U_FULL_W'(0));

  // cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      if (status_o.is_newline) begin
        row_q <= inc_sat(row_sot);
        col_q <= '0;
      end else begin
        row_q <= row_sot;
        col_q <= col_sot;
      end
    end else if (cmd_i.base) begin
      if (wrap) begin
        col_q <= '0;
        row_q <= inc_sat(row_q);
      end else begin
        col_q <= inc_sat(col_q);
      end
    end
  end

  // glyph position pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      code_q <= char_code_i;
    end
    if (cmd_i.mul) begin
      prod_x_q <= PROD_W'(col_q) * PROD_W'(cfg_i.glyph_width);
      prod_y_q <= PROD_W'(row_q) * PROD_W'(cfg_i.glyph_height);
    end
    if (cmd_i.base) begin
      x0_q <= POS_W'(cfg_i.origin_x) + POS_W'(prod_x_q);
      y0_q <= POS_W'(cfg_i.origin_y) + POS_W'(prod_y_q);
    end
    if (cmd_i.offs) begin
      xs_q    <= x0_q + POS_W'(cfg_i.shadow_dx);
      ys_q    <= y0_q + POS_W'(cfg_i.shadow_dy);
      alpha_q <= alpha_prod[2*ALPHA_W-1:ALPHA_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_q <= '0;
    end else if (cmd_i.offs) begin
      // skip the shadow quad when shadow is off
      vtx_q <= cfg_i.shadow_en ? VTX_CNT_W'(0) : VTX_CNT_W'(4);
    end else if (cmd_i.emit) begin
      vtx_q <= vtx_q + VTX_CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      vertex_x_o     <= sat16(vx);
      vertex_y_o     <= sat16(vy);
      tex_u_o        <= u_full[TEX_U_W-1:0];
      tex_v_o        <= bottom ? TEX_V_W'(CELL_H) : TEX_V_W'(0);
      vertex_color_o <= text_phase ? cfg_i.text_color : COLOR_W'(alpha_q);
      last_of_run_o  <= &vtx_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/core/gqg_checker.sv
`default_nettype none
`include "assert_macros.svh"

module gqg_checker import gqg_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic [CODE_W-1:0]  char_code_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [COORD_W-1:0] vertex_x_i,
  input wire logic [COLOR_W-1:0] vertex_color_i,
  input wire logic [TEX_V_W-1:0] tex_v_i,
  input wire logic               last_of_run_i
);

  logic in_beat, glyph_beat, newline_beat;

  assign in_beat      = in_valid_i && in_ready_i;
  assign newline_beat = in_beat && (char_code_i == CHAR_NEWLINE);
  assign glyph_beat   = in_beat && (char_code_i != CHAR_NEWLINE);

  // a glyph occupies the block for its setup cycles
  `GQG_ASSERT_NXT(a_glyph_busy, glyph_beat, !in_ready_i, "ready high right after a glyph")

  // the block is ready again in the cycle after a newline
  `GQG_ASSERT_NXT(a_newline_fast, newline_beat, in_ready_i, "not ready after a newline")

  // the final vertex of a character is a bottom corner
  `GQG_ASSERT_IMP(a_last_bottom, out_valid_i && last_of_run_i, tex_v_i == TEX_V_W'(CELL_H),
                  "last vertex not on bottom edge")

  `GQG_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(vertex_x_i) && $stable(vertex_color_i),
                  "stalled vertex beat changed")

endmodule

bind glyph_quad_generator_unit gqg_checker u_gqg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (chr_in.valid),
  .in_ready_i     (chr_in.ready),
  .char_code_i    (chr_in.char_code),
  .out_valid_i    (vtx_out.valid),
  .out_ready_i    (vtx_out.ready),
  .vertex_x_i     (vtx_out.vertex_x),
  .vertex_color_i (vtx_out.vertex_color),
  .tex_v_i        (vtx_out.tex_v),
  .last_of_run_i  (vtx_out.last_of_run)
);

`default_nettype wire
